@@ rtl/huffman_code_bit_packer_core_macros.svh @@
// Assertion macros shared by the Huffman bit packer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define HCBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication.
`define HCBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `HCBP_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

// Next-cycle implication.
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `HCBP_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

@@ rtl/hcbp_pkg.sv @@
// Package for the Huffman code bit packer: widths, mode codes, shared types.
// No dependencies; used by hcbp_packer, the top module and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

   localparam int SYMBOL_BITS  = 16;
   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_W       = 32;
   localparam int LEN_W        = 6;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int BYTE_W       = 8;
   localparam int PEND_W       = BYTE_W - 1;
   localparam int ACC_W        = PEND_W + CODE_W;
   localparam int CNT_W        = $clog2(ACC_W + 1);
   localparam int TABLE_DEPTH  = 1 << SYMBOL_BITS;
   localparam int ENTRY_W      = LEN_W + CODE_W;
   localparam int REQ_FIELDS_W = 16 + LEN_W + CODE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int MODE_W       = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } mode_type;

   // One looked-up item handed from the table stage to the bit buffer.
   typedef struct packed {
      logic              valid;
      logic              flush;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } entry_type;

   // Mask with the low len bits set.
   function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
      logic [CODE_W-1:0] m;
      if (len >= LEN_W'(CODE_W)) begin
         m = '1;
      end else begin
         m = (CODE_W'(1) << len) - CODE_W'(1);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ rtl/hcbp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/hcbp_packer.sv @@
// Bit buffer of the Huffman packer: appends codes, cuts bytes, pads on flush.
// Depends on hcbp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_bit_packer_core_macros.svh"

module hcbp_packer
   import hcbp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [BYTE_W-1:0] key,
   input  wire entry_type         ent,
   output logic                   take,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic      [BYTE_W-1:0] out_byte,
   output logic                   out_last
);

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              flush_ff, flush_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              free;
   logic              emit;
   logic [PEND_W-1:0] keep;
   logic [BYTE_W-1:0] pad;
   logic [BYTE_W-1:0] cut;

   // Fewer than eight bits held means only pending bits remain.
   assign free = (cnt_ff < CNT_W'(BYTE_W));
   assign take = ent.valid && free;
   assign emit = !free && (!out_valid_ff || out_ready);

   assign keep = acc_ff[PEND_W-1:0] & ((PEND_W'(1) << cnt_ff[2:0]) - PEND_W'(1));
   assign pad  = BYTE_W'({1'b0, keep} << (4'(BYTE_W) - {1'b0, cnt_ff[2:0]}));
   assign cut  = BYTE_W'(acc_ff >> (cnt_ff - CNT_W'(BYTE_W)));

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      if (take) begin
         if (ent.flush) begin
            acc_in   = ACC_W'(pad);
            cnt_in   = (cnt_ff == '0) ? '0 : CNT_W'(BYTE_W);
            flush_in = (cnt_ff != '0);
         end else begin
            acc_in = (ACC_W'(keep) << ent.len) | ACC_W'(ent.code);
            cnt_in = cnt_ff + CNT_W'(ent.len);
         end
      end else if (emit) begin
         cnt_in   = cnt_ff - CNT_W'(BYTE_W);
         flush_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cut ^ key;
         out_last_in  = flush_ff;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         out_valid_ff <= out_valid_in;
      end
      acc_ff      <= acc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

   `HCBP_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(ACC_W), "bit count overflow")
   `HCBP_ASSERT_IMP(a_flush_one_byte, clock, reset, flush_ff, cnt_ff == CNT_W'(BYTE_W), "flush byte count wrong")
   `HCBP_ASSERT_NEXT(a_emit_loads_out, clock, reset, emit, out_valid_ff && (out_last_ff == $past(flush_ff)), "byte not presented after emit")

endmodule

`default_nettype wire

@@ rtl/huffman_code_bit_packer_core.sv @@
// Huffman code bit packer: items pass the lookup stage, the bit buffer and the output register.
// Throughput: one transaction per cycle for items that yield no byte; an item yielding bytes
// (four at most) holds the bit buffer until they are sent, and longer while rsp_tready is low.
// Reset is synchronous: after it the code table is cleared in a pass over all 65536 entries, one
// entry per cycle, during which req_tready stays low; csr writes are taken throughout.
// Depends on hcbp_pkg, hcbp_ram, hcbp_packer and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "huffman_code_bit_packer_core_macros.svh"

module huffman_code_bit_packer_core
   import hcbp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // symbol, code_length, code_bits, zero pad
   input  wire logic [MODE_W-1:0]     req_tuser,  // mode
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [BYTE_W-1:0]     rsp_tdata,  // out_byte
   output logic                       rsp_tlast,  // last_byte
   // Key register write channel.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [BYTE_W-1:0]     csr_data
);

   // Request fields, unpacked from the lowest bit up.
   logic [15:0]        req_symbol;
   logic [LEN_W-1:0]   req_code_length;
   logic [CODE_W-1:0]  req_code_bits;
   mode_type           req_mode;

   assign req_symbol      = req_tdata[15:0];
   assign req_code_length = req_tdata[16 +: LEN_W];
   assign req_code_bits   = req_tdata[16 + LEN_W +: CODE_W];
   assign req_mode        = mode_type'(req_tuser);

   // The XOR key register. Writes are only expected while the block is idle.
   logic [BYTE_W-1:0] key_ff, key_in;

   assign csr_ready = 1'b1;
   assign key_in    = (csr_valid && csr_ready) ? csr_data : key_ff;

   // Clearing pass: the length field of every table entry must read zero after reset,
   // so the whole table is swept once, one entry per cycle, before items are taken.
   logic                   clr_active_ff, clr_active_in;
   logic [SYMBOL_BITS-1:0] clr_addr_ff, clr_addr_in;

   assign clr_active_in = clr_active_ff && (clr_addr_ff != '1);
   assign clr_addr_in   = clr_active_ff ? clr_addr_ff + SYMBOL_BITS'(1) : clr_addr_ff;

   // Lookup stage: holds an encode or flush transaction while its table read returns.
   logic s1_valid_ff, s1_valid_in;
   logic s1_flush_ff, s1_flush_in;
   logic pk_take;
   logic req_accept;
   logic is_load, is_encode, is_flush;

   always_comb begin
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      unique case (req_mode)
         MODE_LOAD:   is_load   = 1'b1;
         MODE_ENCODE: is_encode = 1'b1;
         MODE_FLUSH:  is_flush  = 1'b1;
         default:     ;
      endcase
   end

   // Outside the clearing pass, a new transaction is taken whenever the lookup stage is empty or
   // hands its item on in this cycle; loads finish at acceptance and never occupy the lookup stage.
   assign req_tready = !clr_active_ff && (!s1_valid_ff || pk_take);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_flush_in = s1_flush_ff;
      if (req_accept && (is_encode || is_flush)) begin
         s1_valid_in = 1'b1;
         s1_flush_in = is_flush;
      end else if (pk_take) begin
         s1_valid_in = 1'b0;
      end
   end

   // Code table: one memory entry per symbol, {length, masked code bits}.
   // A load writes at its acceptance edge, so an encode of the same symbol accepted in
   // the next cycle already reads the new entry; no forwarding path is needed.
   logic [LEN_W-1:0]       load_len;
   logic                   ram_wr_en;
   logic [SYMBOL_BITS-1:0] ram_wr_addr;
   logic [ENTRY_W-1:0]     ram_wr_data;
   logic                   ram_rd_en;
   logic [ENTRY_W-1:0]     ram_rd_data;

   assign load_len    = (req_code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                                : req_code_length;
   assign ram_wr_en   = clr_active_ff || (req_accept && is_load);
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : req_symbol[SYMBOL_BITS-1:0];
   assign ram_wr_data = clr_active_ff ? '0
                                      : {load_len, req_code_bits & code_mask(load_len)};
   assign ram_rd_en   = req_accept && is_encode;

   hcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_symbol[SYMBOL_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // The read data register holds its value until the next encode read, which cannot
   // happen before the lookup stage has handed its item to the bit buffer.
   entry_type ent;

   always_comb begin
      ent.valid = s1_valid_ff;
      ent.flush = s1_flush_ff;
      ent.len   = ram_rd_data[CODE_W +: LEN_W];
      ent.code  = ram_rd_data[CODE_W-1:0];
   end

   hcbp_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .ent       (ent),
      .take      (pk_take),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s1_flush_ff   <= 1'b0;
      end else begin
         key_ff        <= key_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         s1_flush_ff   <= s1_flush_in;
      end
   end

   `HCBP_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !pk_take, s1_valid_ff && $stable(s1_flush_ff), "lookup item lost while stalled")
   `HCBP_ASSERT_IMP(a_clear_done, clock, reset, $fell(clr_active_ff), $past(clr_addr_ff) == '1, "clearing pass ended early")
   `HCBP_ASSERT_IMP(a_clear_blocks, clock, reset, clr_active_ff, !req_tready, "request taken in clear")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for huffman_code_bit_packer_core: code table loads, symbol
// encoding, flushes and key changes, checked byte by byte by a scoreboard class.
// Depends on hcbp_pkg and the huffman_code_bit_packer_core RTL.
`timescale 1ns / 1ps

import hcbp_pkg::*;

// One expected output byte together with its end-of-stream mark.
typedef struct packed {
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;
} packed_byte_type;

// Scoreboard: keeps its own copy of the code table, the pending bit buffer and the key,
// turns every accepted request into the bytes it should produce, and checks the
// output stream against them in order.
class packer_scoreboard;
   bit [LEN_W-1:0]  len_tab [TABLE_DEPTH];
   bit [CODE_W-1:0] code_tab [TABLE_DEPTH];
   bit [PEND_W-1:0] pend_bits;
   bit [2:0]        pend_cnt;
   bit [BYTE_W-1:0] key;
   packed_byte_type expected_bytes [$];
   int unsigned     errors;

   function void set_key(input logic [BYTE_W-1:0] value);
      key = value;
   endfunction

   function int unsigned outstanding();
      return expected_bytes.size();
   endfunction

   function void push_byte(input logic [BYTE_W-1:0] value, input logic last);
      packed_byte_type rec;
      rec.out_byte  = value ^ key;
      rec.last_byte = last;
      expected_bytes.push_back(rec);
   endfunction

   // Applies one accepted request and queues the bytes it produces.
   function void absorb_item(input logic [MODE_W-1:0] mode, input logic [15:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
      int unsigned n_len;
      int unsigned total;
      int unsigned n;
      logic [63:0] acc;
      logic [63:0] mask;
      logic [63:0] shifted;
      logic [15:0] tail;
      case (mode)
         MODE_LOAD: begin
            n_len = (len > LEN_LIMIT) ? LEN_LIMIT : len;
            mask = (64'd1 << n_len) - 64'd1;
            len_tab[sym] = LEN_W'(n_len);
            code_tab[sym] = code & mask[CODE_W-1:0];
         end
         MODE_ENCODE: begin
            n_len = len_tab[sym];
            if (n_len != 0) begin
               acc = ({57'd0, pend_bits} << n_len) | {32'd0, code_tab[sym]};
               total = pend_cnt + n_len;
               n = 0;
               while (total >= 8 && n < 4) begin
                  total -= 8;
                  shifted = acc >> total;
                  push_byte(shifted[7:0], 1'b0);
                  n++;
               end
               pend_cnt = total[2:0];
               mask = (64'd1 << pend_cnt) - 64'd1;
               pend_bits = acc[PEND_W-1:0] & mask[PEND_W-1:0];
            end
         end
         MODE_FLUSH: begin
            // Only a buffer holding bits yields a padded closing byte.
            if (pend_cnt != 0) begin
               tail = {9'd0, pend_bits} << (8 - pend_cnt);
               push_byte(tail[7:0], 1'b1);
            end
            pend_bits = '0;
            pend_cnt = '0;
         end
         default: begin
         end
      endcase
   endfunction

   function void check_byte(input logic [BYTE_W-1:0] data, input logic last);
      packed_byte_type rec;
      if (expected_bytes.size() == 0) begin
         $error("unexpected output byte: out_byte %h last_byte %b", data, last);
         errors++;
         return;
      end
      rec = expected_bytes.pop_front();
      if (rec.out_byte !== data) begin
         $error("out_byte mismatch: expected %h, actual %h", rec.out_byte, data);
         errors++;
      end
      if (rec.last_byte !== last) begin
         $error("last_byte mismatch: expected %b, actual %b", rec.last_byte, last);
         errors++;
      end
   endfunction
endclass

module tb_top;

   // The fourth mode code has no meaning to the block; it must be dropped silently.
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
   // Quiet cycles after the last expected byte before the key may change; they cover
   // requests that produce no output and may still be inside the block.
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PER_PHASE = 80;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // symbol, code_length, code_bits, zero pad
   logic [MODE_W-1:0]     req_tuser;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [BYTE_W-1:0]     rsp_tdata;  // out_byte
   logic                  rsp_tlast;  // last_byte
   logic                  csr_valid;
   logic                  csr_ready;
   logic [BYTE_W-1:0]     csr_data;

   packer_scoreboard sb = new();

   // Symbols loaded so far; encode requests mostly draw from this list so that
   // the random part exercises real codes rather than empty table entries.
   logic [15:0] loaded_syms [$];
   int unsigned req_calm;
   int unsigned rsp_calm;

   huffman_code_bit_packer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Idle cycles before the next transaction on one side. Now and then a run of
   // transactions goes through with no idling at all.
   function automatic int unsigned draw_gap(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         calm = $urandom_range(4, 24);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // Presents one request and returns at the edge where it is accepted. The valid stays
   // high afterwards, so a following request with no gap goes out back to back.
   task automatic send_req(input logic [MODE_W-1:0] mode, input logic [15:0] sym,
                           input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code);
      int unsigned gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W - 16 - LEN_W - CODE_W){1'b0}}, code, len, sym};
      do @(posedge clock); while (!req_tready);
      sb.absorb_item(mode, sym, len, code);
      if (mode == MODE_LOAD) begin
         loaded_syms.push_back(sym);
      end
   endtask

   task automatic write_key(input logic [BYTE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_key(value);
   endtask

   // Stops the request stream, waits for every expected byte, then lets the pipeline
   // run dry so that the block is idle before the next key write.
   task automatic settle_phase();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Directed opening: field extremes, every mode, saturated and zero lengths,
   // the maximum of four bytes per symbol and flushes with and without pending bits.
   task automatic run_directed();
      send_req(MODE_FLUSH,   16'h0000, 6'd0,  32'h0000_0000);  // nothing pending
      send_req(MODE_ENCODE,  16'h1234, 6'd0,  32'h0000_0000);  // never loaded
      send_req(MODE_LOAD,    16'h0000, 6'd1,  32'hFFFF_FFFF);
      send_req(MODE_LOAD,    16'hFFFF, 6'd32, 32'hFFFF_FFFF);
      send_req(MODE_LOAD,    16'h00FF, 6'd7,  32'h0000_0055);
      send_req(MODE_LOAD,    16'h8001, 6'd63, 32'hDEAD_BEEF);  // saturates to 32 bits
      send_req(MODE_LOAD,    16'h4242, 6'd0,  32'hFFFF_FFFF);  // zero length
      send_req(MODE_LOAD,    16'h7E7E, 6'd33, 32'h1234_5678);  // just above the limit
      send_req(MODE_ENCODE,  16'h0000, 6'd0,  32'h0000_0000);
      send_req(MODE_ENCODE,  16'h00FF, 6'd0,  32'h0000_0000);  // completes one byte
      send_req(MODE_ENCODE,  16'h0000, 6'd0,  32'h0000_0000);
      send_req(MODE_ENCODE,  16'hFFFF, 6'd0,  32'h0000_0000);  // four bytes out
      send_req(MODE_ENCODE,  16'h8001, 6'd0,  32'h0000_0000);  // four bytes out
      send_req(MODE_ENCODE,  16'h4242, 6'd0,  32'h0000_0000);  // loaded with no bits
      send_req(MODE_IGNORED, 16'hFFFF, 6'd63, 32'hFFFF_FFFF);
      send_req(MODE_FLUSH,   16'hFFFF, 6'd63, 32'hFFFF_FFFF);
      send_req(MODE_FLUSH,   16'h0000, 6'd0,  32'h0000_0000);  // buffer already empty
      send_req(MODE_ENCODE,  16'h00FF, 6'd0,  32'h0000_0000);  // seven bits pending
      send_req(MODE_FLUSH,   16'h0000, 6'd0,  32'h0000_0000);
      send_req(MODE_ENCODE,  16'hFFFF, 6'd0,  32'h0000_0000);  // byte aligned, no rest
      send_req(MODE_FLUSH,   16'h0000, 6'd0,  32'h0000_0000);
      send_req(MODE_ENCODE,  16'h7E7E, 6'd0,  32'h0000_0000);
      send_req(MODE_FLUSH,   16'h0000, 6'd0,  32'h0000_0000);
   endtask

   // Random code length: mostly short codes, some near the 32-bit limit, a few zero
   // and a few above the limit.
   function automatic logic [LEN_W-1:0] draw_length();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return LEN_W'($urandom_range(33, 63));
      end else if (pick <= 4) begin
         return LEN_W'($urandom_range(25, 32));
      end
      return LEN_W'($urandom_range(1, 12));
   endfunction

   // Random traffic shaped like real streams: loads interleaved with runs of encodes
   // and an occasional flush. Ignored requests are sprinkled in but not counted.
   task automatic run_random(input int unsigned count);
      int unsigned done;
      int unsigned pick;
      logic [15:0] sym;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 1) == 0) begin
            sym = 16'($urandom_range(0, 255));  // symbol in the byte range
         end else begin
            sym = 16'($urandom);
         end
         if (pick < 20) begin
            if (loaded_syms.size() != 0 && $urandom_range(0, 3) == 0) begin
               sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
            send_req(MODE_LOAD, sym, draw_length(), 32'($urandom));
            done++;
         end else if (pick < 86) begin
            if (loaded_syms.size() != 0 && $urandom_range(0, 99) < 85) begin
               sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
            send_req(MODE_ENCODE, sym, LEN_W'($urandom), 32'($urandom));
            done++;
         end else if (pick < 96) begin
            send_req(MODE_FLUSH, sym, LEN_W'($urandom), 32'($urandom));
            done++;
         end else begin
            send_req(MODE_IGNORED, sym, LEN_W'($urandom), 32'($urandom));
         end
      end
   endtask

   // Output side: stalls a random number of cycles before each byte, then holds
   // ready until a transaction completes.
   initial begin
      int unsigned gap;
      rsp_tready <= 1'b0;
      rsp_calm = 0;
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Every accepted output byte goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_byte(rsp_tdata, rsp_tlast);
      end
   end

   // Main sequence. The key is written after reset (the block accepts key writes
   // during its table clearing pass) and again between phases, covering both extremes.
   initial begin
      logic [BYTE_W-1:0] key_plan [4];
      key_plan[0] = 8'h00;
      key_plan[1] = 8'hFF;
      key_plan[2] = 8'($urandom_range(1, 254));
      key_plan[3] = 8'($urandom_range(1, 254));
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      req_calm = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_key(8'hA5);
      run_directed();
      settle_phase();
      foreach (key_plan[i]) begin
         write_key(key_plan[i]);
         run_random(RANDOM_PER_PHASE);
         settle_phase();
      end
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: ends the run as a failure with ample margin over the table clearing pass
   // and a correct run.
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
